### src/dppick_pkg.sv
// ----------------------------------------------------------------------------
// dppick_pkg
// Shared types and constants of the dependency-aware priority task picker.
// ----------------------------------------------------------------------------
`default_nettype none

package dppick_pkg;

  localparam int TASK_W   = 5;
  localparam int CLASS_W  = 8;
  localparam int PRIO_W   = 32;
  localparam int START_W  = 6;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 3;

  localparam logic [COUNT_W-1:0] MAX_IN_FLIGHT_RST = 7'd2;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_COMPLETE = 2'd2,
    OP_CLEAR    = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_REGISTERED = 3'd0,
    ST_DISPATCHED = 3'd1,
    ST_COMPLETED  = 3'd2,
    ST_WAIT       = 3'd3,
    ST_ALL_DONE   = 3'd4,
    ST_CYCLIC     = 3'd5,
    ST_ERROR      = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_TAIL = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

### src/dependency_priority_task_picker.sv
// ----------------------------------------------------------------------------
// dependency_priority_task_picker
// Task table with dependency masks; picks the ready task of lowest class and
// highest priority on each dispatch request that passes the in-flight limit.
// ----------------------------------------------------------------------------
// Register, complete and clear items are answered at the edge that accepts
// them: the result is registered there. A dispatch item that reaches the
// scan walks the class and priority memories one slot per cycle through a
// single compare unit in S_SCAN, behind a read register for the memory
// data, drains the last read in S_TAIL and commits its result in S_FIN.
// in_tready is low while a scan runs or while an unread result would block
// the next one. No clearing pass is needed after reset.
`default_nettype none

module dependency_priority_task_picker
  import dppick_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wen,
  input  wire logic [COUNT_W-1:0]   cfg_wdata,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // [7:0] sched_class, [39:8] priority_req, [45:40] dep_start,
  // [50:46] task_id, [55:51] zero
  input  wire logic [55:0]          in_tdata,
  // [1:0] opcode
  input  wire logic [1:0]           in_tuser,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // [4:0] task_out, [11:5] in_flight, [15:12] zero
  output logic [15:0]               out_tdata,
  // [2:0] status
  output logic [STATUS_W-1:0]       out_tuser
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [CLASS_W-1:0] in_class;
  logic [PRIO_W-1:0]  in_prio;
  logic [START_W-1:0] in_start;
  logic [TASK_W-1:0]  in_task;
  opcode_t            in_op;

  assign in_class = in_tdata[7:0];
  assign in_prio  = in_tdata[39:8];
  assign in_start = in_tdata[45:40];
  assign in_task  = in_tdata[50:46];
  assign in_op    = opcode_t'(in_tuser);

  state_t                   state_r, state_nxt;
  logic [COUNT_W-1:0]       max_r;
  logic [TABLE_DEPTH-1:0]   pend_r, pend_nxt;
  logic [TABLE_DEPTH-1:0]   run_r, run_nxt;
  logic [TABLE_DEPTH-1:0]   mask_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]   mask_nxt [TABLE_DEPTH];
  logic [CNT_W-1:0]         slot_r, slot_nxt;
  logic [CNT_W-1:0]         pcnt_r, pcnt_nxt;
  logic [COUNT_W-1:0]       rcnt_r, rcnt_nxt;

  logic [IDX_W-1:0]         scan_r, scan_nxt;
  logic                     stg_v_r, stg_v_nxt;
  logic                     elig_r, elig_nxt;
  logic [IDX_W-1:0]         cand_r, cand_nxt;
  logic [CLASS_W-1:0]       rd_cls_r;
  logic [PRIO_W-1:0]        rd_prio_r;
  logic                     found_r, found_nxt;
  logic [IDX_W-1:0]         best_r, best_nxt;
  logic [CLASS_W-1:0]       best_cls_r, best_cls_nxt;
  logic [PRIO_W-1:0]        best_prio_r, best_prio_nxt;

  logic                     ov_r, ov_nxt;
  status_t                  ost_r, ost_nxt;
  logic [TASK_W-1:0]        otask_r, otask_nxt;
  logic [COUNT_W-1:0]       ocnt_r, ocnt_nxt;

  logic [CLASS_W-1:0]       cls_mem [TABLE_DEPTH];
  logic [PRIO_W-1:0]        prio_mem [TABLE_DEPTH];
  logic                     mem_we;
  logic [IDX_W-1:0]         wr_idx;

  logic                     in_acc;
  logic [TABLE_DEPTH-1:0]   reg_mask;
  logic [IDX_W-1:0]         done_idx;
  logic                     better;

  assign in_tready  = (state_r == S_IDLE) && (!ov_r || out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = ov_r;
  assign out_tuser  = ost_r;
  assign out_tdata  = {4'd0, ocnt_r, otask_r};

  assign wr_idx   = slot_r[IDX_W-1:0];
  assign done_idx = IDX_W'(in_task);

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      reg_mask[i] = (7'(i) >= {1'b0, in_start}) && (CNT_W'(i) < slot_r) &&
                    (pend_r[i] || run_r[i]);
    end
  end

  assign better = !found_r || (rd_cls_r < best_cls_r) ||
                  ((rd_cls_r == best_cls_r) && ($signed(rd_prio_r) > $signed(best_prio_r)));

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    run_nxt       = run_r;
    mask_nxt      = mask_r;
    slot_nxt      = slot_r;
    pcnt_nxt      = pcnt_r;
    rcnt_nxt      = rcnt_r;
    scan_nxt      = scan_r;
    stg_v_nxt     = stg_v_r;
    elig_nxt      = elig_r;
    cand_nxt      = cand_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    best_cls_nxt  = best_cls_r;
    best_prio_nxt = best_prio_r;
    ov_nxt        = ov_r && !out_tready;
    ost_nxt       = ost_r;
    otask_nxt     = otask_r;
    ocnt_nxt      = ocnt_r;
    mem_we        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ov_nxt    = 1'b1;
          otask_nxt = '0;
          unique case (in_op)
            OP_REGISTER: begin
              if (slot_r == CNT_W'(TABLE_DEPTH)) begin
                ost_nxt = ST_ERROR;
              end else begin
                mem_we           = 1'b1;
                pend_nxt[wr_idx] = 1'b1;
                run_nxt[wr_idx]  = 1'b0;
                mask_nxt[wr_idx] = reg_mask;
                slot_nxt         = slot_r + 1'b1;
                pcnt_nxt         = pcnt_r + 1'b1;
                ost_nxt          = ST_REGISTERED;
                otask_nxt        = TASK_W'(wr_idx);
              end
            end
            OP_DISPATCH: begin
              if (pcnt_r == '0 && rcnt_r == '0) begin
                ost_nxt = ST_ALL_DONE;
              end else if (rcnt_r >= max_r) begin
                ost_nxt = ST_WAIT;
              end else begin
                ov_nxt    = 1'b0;
                state_nxt = S_SCAN;
                scan_nxt  = '0;
                stg_v_nxt = 1'b0;
                found_nxt = 1'b0;
              end
            end
            OP_COMPLETE: begin
              if ((32'(in_task) >= TABLE_DEPTH) || !run_r[done_idx]) begin
                ost_nxt = ST_ERROR;
              end else begin
                run_nxt[done_idx] = 1'b0;
                if (rcnt_r != '0) begin
                  rcnt_nxt = rcnt_r - 1'b1;
                end
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                  mask_nxt[i][done_idx] = 1'b0;
                end
                ost_nxt   = ST_COMPLETED;
                otask_nxt = in_task;
              end
            end
            OP_CLEAR: begin
              pend_nxt = '0;
              run_nxt  = '0;
              for (int i = 0; i < TABLE_DEPTH; i++) begin
                mask_nxt[i] = '0;
              end
              slot_nxt = '0;
              pcnt_nxt = '0;
              rcnt_nxt = '0;
              ost_nxt  = ST_ALL_DONE;
            end
            default: ;
          endcase
          ocnt_nxt = rcnt_nxt;
        end
      end
      S_SCAN: begin
        stg_v_nxt = 1'b1;
        elig_nxt  = pend_r[scan_r] && (mask_r[scan_r] == '0);
        cand_nxt  = scan_r;
        if (stg_v_r && elig_r && better) begin
          found_nxt     = 1'b1;
          best_nxt      = cand_r;
          best_cls_nxt  = rd_cls_r;
          best_prio_nxt = rd_prio_r;
        end
        if (scan_r == IDX_W'(TABLE_DEPTH - 1)) begin
          state_nxt = S_TAIL;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_TAIL: begin
        stg_v_nxt = 1'b0;
        if (stg_v_r && elig_r && better) begin
          found_nxt     = 1'b1;
          best_nxt      = cand_r;
          best_cls_nxt  = rd_cls_r;
          best_prio_nxt = rd_prio_r;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        ov_nxt    = 1'b1;
        otask_nxt = '0;
        if (found_r) begin
          pend_nxt[best_r] = 1'b0;
          run_nxt[best_r]  = 1'b1;
          pcnt_nxt         = pcnt_r - 1'b1;
          rcnt_nxt         = rcnt_r + 1'b1;
          ost_nxt          = ST_DISPATCHED;
          otask_nxt        = TASK_W'(best_r);
        end else if (rcnt_r != '0) begin
          ost_nxt = ST_WAIT;
        end else begin
          ost_nxt = ST_CYCLIC;
        end
        ocnt_nxt  = rcnt_nxt;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cls_mem[wr_idx]  <= in_class;
      prio_mem[wr_idx] <= in_prio;
    end
    rd_cls_r  <= cls_mem[scan_r];
    rd_prio_r <= prio_mem[scan_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      max_r   <= MAX_IN_FLIGHT_RST;
      pend_r  <= '0;
      run_r   <= '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        mask_r[i] <= '0;
      end
      slot_r  <= '0;
      pcnt_r  <= '0;
      rcnt_r  <= '0;
      scan_r  <= '0;
      stg_v_r <= 1'b0;
      found_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wen) begin
        max_r <= cfg_wdata;
      end
      pend_r  <= pend_nxt;
      run_r   <= run_nxt;
      mask_r  <= mask_nxt;
      slot_r  <= slot_nxt;
      pcnt_r  <= pcnt_nxt;
      rcnt_r  <= rcnt_nxt;
      scan_r  <= scan_nxt;
      stg_v_r <= stg_v_nxt;
      found_r <= found_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elig_r      <= elig_nxt;
    cand_r      <= cand_nxt;
    best_r      <= best_nxt;
    best_cls_r  <= best_cls_nxt;
    best_prio_r <= best_prio_nxt;
    ost_r       <= ost_nxt;
    otask_r     <= otask_nxt;
    ocnt_r      <= ocnt_nxt;
  end

endmodule

`default_nettype wire
